@@ hw/rtl/rtc_snapshot_bcd_decode_assert.svh @@
// Assertion macros for the checker file of the RTC snapshot decoder.
`ifndef RTC_SNAPSHOT_BCD_DECODE_ASSERT_SVH
`define RTC_SNAPSHOT_BCD_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RSBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RSBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rsbd_pkg.sv @@
// Types and constants for the RTC snapshot decoder.
package rsbd_pkg;

    localparam int unsigned InWidth  = 64;
    localparam int unsigned OutWidth = 48;
    localparam int unsigned ResWidth = 45;

    localparam logic [11:0] YearBase = 12'd2000;

    // Raw register snapshot, control byte in the low bits.
    typedef struct packed {
        logic [7:0] years_raw;
        logic [7:0] months_raw;
        logic [7:0] weekday_raw;
        logic [7:0] days_raw;
        logic [7:0] hours_raw;
        logic [7:0] minutes_raw;
        logic [7:0] sec_reg;
        logic [7:0] control_byte;
    } t_snapshot;

    // Decoded result, valid_res in the low bit.
    typedef struct packed {
        logic        mode_24h;
        logic        clock_running;
        logic        oscillator_ok;
        logic [11:0] year;
        logic [3:0]  month;
        logic [2:0]  weekday;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        valid_res;
    } t_result;

endpackage

@@ hw/rtl/rsbd_bcd.sv @@
// Two-digit BCD to binary converter with digit and upper-limit check.
module rsbd_bcd
    import rsbd_pkg::*;
(
    input  logic [7:0] i_code,
    input  logic [6:0] i_limit,
    output logic       o_ok,
    output logic [6:0] o_val
);

    logic [3:0] w_hi;
    logic [3:0] w_lo;

    assign w_hi  = i_code[7:4];
    assign w_lo  = i_code[3:0];
    // hi*10 = hi*8 + hi*2
    assign o_val = {w_hi, 3'b000} + {2'b00, w_hi, 1'b0} + {3'b000, w_lo};
    assign o_ok  = (w_hi <= 4'd9) && (w_lo <= 4'd9) && (o_val <= i_limit);

endmodule

@@ hw/rtl/rsbd_decode.sv @@
// Field masking, BCD decode and calendar checks for one snapshot.
module rsbd_decode
    import rsbd_pkg::*;
(
    input  t_snapshot i_snap,
    output t_result   o_res
);

    logic       w_twelve;
    logic       w_pm;
    logic       w_sec_ok, w_min_ok, w_h24_ok, w_h12_ok, w_day_ok, w_mon_ok, w_yr_ok;
    logic [6:0] w_sec, w_min, w_h24, w_h12, w_day, w_mon, w_yr;
    logic [4:0] w_hour;
    logic       w_hour_ok;
    logic [2:0] w_wd;
    logic       w_wd_ok;
    logic [4:0] w_mlen;
    logic       w_ok;

    assign w_twelve = i_snap.control_byte[1];
    assign w_pm     = i_snap.hours_raw[5];

    rsbd_bcd u_sec (.i_code({1'b0, i_snap.sec_reg[6:0]}), .i_limit(7'd59),
                    .o_ok(w_sec_ok), .o_val(w_sec));
    rsbd_bcd u_min (.i_code({1'b0, i_snap.minutes_raw[6:0]}), .i_limit(7'd59),
                    .o_ok(w_min_ok), .o_val(w_min));
    rsbd_bcd u_h24 (.i_code({2'b00, i_snap.hours_raw[5:0]}), .i_limit(7'd23),
                    .o_ok(w_h24_ok), .o_val(w_h24));
    rsbd_bcd u_h12 (.i_code({3'b000, i_snap.hours_raw[4:0]}), .i_limit(7'd12),
                    .o_ok(w_h12_ok), .o_val(w_h12));
    rsbd_bcd u_day (.i_code({2'b00, i_snap.days_raw[5:0]}), .i_limit(7'd31),
                    .o_ok(w_day_ok), .o_val(w_day));
    rsbd_bcd u_mon (.i_code({3'b000, i_snap.months_raw[4:0]}), .i_limit(7'd12),
                    .o_ok(w_mon_ok), .o_val(w_mon));
    rsbd_bcd u_yr  (.i_code(i_snap.years_raw), .i_limit(7'd99),
                    .o_ok(w_yr_ok), .o_val(w_yr));

    // 12 AM maps to 0, 12 PM stays 12, other PM hours get 12 added
    always_comb begin
        if (!w_twelve) begin
            w_hour    = w_h24[4:0];
            w_hour_ok = w_h24_ok;
        end else begin
            w_hour_ok = w_h12_ok && (w_h12 != 7'd0);
            if (w_h12 == 7'd12) begin
                w_hour = w_pm ? 5'd12 : 5'd0;
            end else begin
                w_hour = w_h12[4:0] + (w_pm ? 5'd12 : 5'd0);
            end
        end
    end

    assign w_wd    = i_snap.weekday_raw[2:0];
    assign w_wd_ok = (i_snap.weekday_raw[7:3] == 5'd0) && (w_wd != 3'd7);

    // Days in month; February is leap when the two-digit year is a multiple of four
    always_comb begin
        if (w_mon[3:0] == 4'd2) begin
            w_mlen = (w_yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else if (w_mon[3:0] inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            w_mlen = 5'd30;
        end else begin
            w_mlen = 5'd31;
        end
    end

    assign w_ok = w_sec_ok && w_min_ok && w_hour_ok && w_day_ok && w_wd_ok
                  && w_mon_ok && w_yr_ok && (w_mon != 7'd0) && (w_day != 7'd0)
                  && (w_day[4:0] <= w_mlen);

    always_comb begin
        o_res = '0;
        if (w_ok) begin
            o_res.valid_res     = 1'b1;
            o_res.second        = w_sec[5:0];
            o_res.minute        = w_min[5:0];
            o_res.hour          = w_hour;
            o_res.day           = w_day[4:0];
            o_res.weekday       = w_wd;
            o_res.month         = w_mon[3:0];
            o_res.year          = YearBase + {5'b00000, w_yr};
            o_res.oscillator_ok = ~i_snap.sec_reg[7];
            o_res.clock_running = ~i_snap.control_byte[5];
            o_res.mode_24h      = ~w_twelve;
        end
    end

endmodule

@@ hw/rtl/rtc_snapshot_bcd_decode.sv @@
// Top level of the RTC snapshot decoder: input register, decode, result register.
//
// Slave stream s_axis_* carries one raw snapshot per request: the control byte
// and the seven BCD time registers, control byte in the low byte of tdata.
// Master stream m_axis_* returns one decoded result per request: valid_res,
// date and time fields, and the oscillator, running and 24-hour flags. When
// any check fails, valid_res is 0 and every other field is 0.
// The result passes from the input register to the result register before it
// shows on m_axis_*; a receiver stall can hold a request in the input register.
// Throughput is one request per cycle while the receiver does not stall, set by
// the single decode stage between the two registers.
// s_axis_tready is high while the input register is empty or the result register
// is empty or being taken, so a new request is taken while a finished result
// waits. When the receiver stalls, the result holds in its register, one more
// request can wait in the input register, then s_axis_tready drops until taken.
// Synchronous active-low reset empties both registers; no request is lost
// or duplicated after reset is released.
module rtc_snapshot_bcd_decode
    import rsbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [7:0] control_byte, [15:8] sec_reg, [23:16] minutes_raw,
    // [31:24] hours_raw, [39:32] days_raw, [47:40] weekday_raw,
    // [55:48] months_raw, [63:56] years_raw
    input  logic [InWidth-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] valid_res, [6:1] second, [12:7] minute, [17:13] hour, [22:18] day,
    // [25:23] weekday, [29:26] month, [41:30] year, [42] oscillator_ok,
    // [43] clock_running, [44] mode_24h, [47:45] zero
    output logic [OutWidth-1:0] m_axis_tdata
);

    logic      r_in_valid, n_in_valid;
    t_snapshot r_in;
    logic      r_out_valid, n_out_valid;
    t_result   r_res;
    t_result   w_res;
    logic      w_adv;
    logic      w_in_fire;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid  = s_axis_tready ? s_axis_tvalid : r_in_valid;
        n_out_valid = w_adv ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in <= t_snapshot'(s_axis_tdata);
        end
        if (w_adv && r_in_valid) begin
            r_res <= w_res;
        end
    end

    rsbd_decode u_decode (
        .i_snap (r_in),
        .o_res  (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutWidth-ResWidth){1'b0}}, r_res};

endmodule

@@ hw/rtl/rsbd_checker.sv @@
// Port-level checker for the RTC snapshot decoder, bound to the top level.
`include "rtc_snapshot_bcd_decode_assert.svh"

module rsbd_checker
    import rsbd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutWidth-1:0] m_axis_tdata
);

    t_result w_res;
    logic    w_acc;
    logic    w_stall;
    logic    w_bad;
    logic    w_good;
    logic    w_range_ok;

    assign w_res   = t_result'(m_axis_tdata[ResWidth-1:0]);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_bad   = m_axis_tvalid && !w_res.valid_res;
    assign w_good  = m_axis_tvalid && w_res.valid_res;

    assign w_range_ok = (w_res.second < 6'd60) && (w_res.minute < 6'd60)
                        && (w_res.hour < 5'd24) && (w_res.day != 5'd0)
                        && (w_res.weekday != 3'd7) && (w_res.month != 4'd0)
                        && (w_res.month <= 4'd12) && (w_res.year >= 12'd2000)
                        && (w_res.year <= 12'd2099);

    `RSBD_ASSERT_NXT(a_stall_valid, i_clk, i_rst_n, w_stall, m_axis_tvalid, "valid dropped")

    `RSBD_ASSERT_NXT(a_stall_data, i_clk, i_rst_n, w_stall, $stable(m_axis_tdata), "data moved")

    `RSBD_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, w_bad, m_axis_tdata == '0, "nonzero fields")

    `RSBD_ASSERT_IMP(a_valid_range, i_clk, i_rst_n, w_good, w_range_ok, "field out of range")

    `RSBD_ASSERT_IMP(a_latency, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_acc, 2), "no request")

endmodule

bind rtc_snapshot_bcd_decode rsbd_checker u_rsbd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb.sv @@
// Self-checking stream testbench for the RTC snapshot decoder.
`timescale 1ns / 100ps

module tb;
    import rsbd_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int MaxGap      = 13;
    localparam int DrainCycles = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [7:0] control_byte, [15:8] sec_reg, [23:16] minutes_raw,
    // [31:24] hours_raw, [39:32] days_raw, [47:40] weekday_raw,
    // [55:48] months_raw, [63:56] years_raw
    logic [InWidth-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [0] valid_res, [6:1] second, [12:7] minute, [17:13] hour, [22:18] day,
    // [25:23] weekday, [29:26] month, [41:30] year, [42] oscillator_ok,
    // [43] clock_running, [44] mode_24h, [47:45] zero
    logic [OutWidth-1:0] m_axis_tdata;

    t_result pending_dates[$];
    int      mismatches = 0;
    int      cycle_count = 0;
    bit      no_idle = 1'b0;

    rtc_snapshot_bcd_decode DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- date/time predictor ----------------

    function automatic bit bcd_field(input logic [7:0] code, input int unsigned lim,
                                     output int unsigned val);
        int unsigned hi;
        int unsigned lo;
        hi  = code[7:4];
        lo  = code[3:0];
        val = 0;
        if (hi > 9 || lo > 9) return 1'b0;
        val = hi * 10 + lo;
        return val <= lim;
    endfunction

    function automatic int unsigned month_days(input int unsigned mo, input int unsigned yy);
        case (mo)
            2: begin
                return (yy % 4 == 0) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic t_result decode_snapshot(input t_snapshot snap);
        t_result     r;
        int unsigned s;
        int unsigned m;
        int unsigned h;
        int unsigned hh;
        int unsigned d;
        int unsigned mo;
        int unsigned yy;
        bit          twelve;
        bit          pm;
        bit          ok;
        r      = '0;
        h      = 0;
        twelve = snap.control_byte[1];
        ok  = bcd_field({1'b0, snap.sec_reg[6:0]}, 59, s);
        ok &= bcd_field({1'b0, snap.minutes_raw[6:0]}, 59, m);
        if (twelve) begin
            ok &= bcd_field({3'b0, snap.hours_raw[4:0]}, 12, hh);
            ok &= (hh != 0);
            pm = snap.hours_raw[5];
            // 12 AM is midnight, 12 PM is noon
            if (hh == 12) h = pm ? 12 : 0;
            else h = hh + (pm ? 12 : 0);
        end else begin
            ok &= bcd_field({2'b0, snap.hours_raw[5:0]}, 23, h);
        end
        ok &= bcd_field({2'b0, snap.days_raw[5:0]}, 31, d);
        ok &= (snap.weekday_raw[7:3] == 5'd0) && (snap.weekday_raw[2:0] != 3'd7);
        ok &= bcd_field({3'b0, snap.months_raw[4:0]}, 12, mo);
        ok &= bcd_field(snap.years_raw, 99, yy);
        ok &= (mo >= 1) && (d >= 1) && (d <= month_days(mo, yy));
        if (ok) begin
            r.valid_res     = 1'b1;
            r.second        = 6'(s);
            r.minute        = 6'(m);
            r.hour          = 5'(h);
            r.day           = 5'(d);
            r.weekday       = snap.weekday_raw[2:0];
            r.month         = 4'(mo);
            r.year          = 12'(YearBase + yy);
            r.oscillator_ok = ~snap.sec_reg[7];
            r.clock_running = ~snap.control_byte[5];
            r.mode_24h      = ~twelve;
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_snapshot snap_of(input logic [7:0] ctrl, sec, mins, hrs,
                                          dd, wd, mon, yr);
        t_snapshot snap;
        snap.control_byte = ctrl;
        snap.sec_reg      = sec;
        snap.minutes_raw  = mins;
        snap.hours_raw    = hrs;
        snap.days_raw     = dd;
        snap.weekday_raw  = wd;
        snap.months_raw   = mon;
        snap.years_raw    = yr;
        return snap;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Legal date and time, random noise in every ignored bit.
    function automatic t_snapshot random_date();
        t_snapshot   snap;
        int unsigned mo;
        int unsigned yy;
        int unsigned hh;
        bit          twelve;
        twelve = $urandom_range(0, 1);
        mo     = $urandom_range(1, 12);
        yy     = $urandom_range(0, 99);
        snap.control_byte = 8'($urandom);
        snap.control_byte[1] = twelve;
        snap.sec_reg     = {1'($urandom), 7'(to_bcd($urandom_range(0, 59)))};
        snap.minutes_raw = {1'($urandom), 7'(to_bcd($urandom_range(0, 59)))};
        if (twelve) begin
            hh = $urandom_range(1, 12);
            snap.hours_raw = {2'($urandom), 1'($urandom), 5'(to_bcd(hh))};
        end else begin
            snap.hours_raw = {2'($urandom), 6'(to_bcd($urandom_range(0, 23)))};
        end
        snap.days_raw    = {2'($urandom), 6'(to_bcd($urandom_range(1, month_days(mo, yy))))};
        snap.weekday_raw = 8'($urandom_range(0, 6));
        snap.months_raw  = {3'($urandom), 5'(to_bcd(mo))};
        snap.years_raw   = to_bcd(yy);
        return snap;
    endfunction

    task automatic send_snapshot(input t_snapshot snap);
        int gap;
        bit taken;
        gap = no_idle ? 0 : $urandom_range(0, MaxGap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= snap;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        pending_dates.push_back(decode_snapshot(snap));
    endtask

    // ---------------- receiver and checker ----------------

    initial begin
        int stall;
        bit taken;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MaxGap);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                taken = m_axis_tvalid;
                @(posedge i_clk);
            end while (!taken);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(negedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[ResWidth-1:0];
            if (pending_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result %h with no request pending", m_axis_tdata);
            end else begin
                want = pending_dates.pop_front();
                check_field("valid_res", want.valid_res, got.valid_res);
                check_field("second", want.second, got.second);
                check_field("minute", want.minute, got.minute);
                check_field("hour", want.hour, got.hour);
                check_field("day", want.day, got.day);
                check_field("weekday", want.weekday, got.weekday);
                check_field("month", want.month, got.month);
                check_field("year", want.year, got.year);
                check_field("oscillator_ok", want.oscillator_ok, got.oscillator_ok);
                check_field("clock_running", want.clock_running, got.clock_running);
                check_field("mode_24h", want.mode_24h, got.mode_24h);
                check_field("pad", 0, m_axis_tdata[OutWidth-1:ResWidth]);
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_legal_extremes();
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h99));
        // twelve-hour: 12 AM, 12 PM, 11 PM, 1 AM
        send_snapshot(snap_of(8'h02, 8'h00, 8'h00, 8'h12, 8'h15, 8'h03, 8'h06, 8'h24));
        send_snapshot(snap_of(8'h02, 8'h30, 8'h45, 8'h32, 8'h15, 8'h03, 8'h06, 8'h24));
        send_snapshot(snap_of(8'h02, 8'h59, 8'h59, 8'h31, 8'h28, 8'h05, 8'h02, 8'h23));
        send_snapshot(snap_of(8'h02, 8'h01, 8'h02, 8'h01, 8'h10, 8'h01, 8'h10, 8'h50));
        // ignored bits all set, oscillator stopped
        send_snapshot(snap_of(8'hDD, 8'hC5, 8'h92, 8'hC8, 8'hE8, 8'h05, 8'hE9, 8'h37));
        send_snapshot(snap_of(8'h20, 8'h10, 8'h20, 8'h13, 8'h30, 8'h02, 8'h11, 8'h88));
        // stop and twelve-hour both set, PM 9 with high bits set
        send_snapshot(snap_of(8'hFF, 8'h07, 8'h08, 8'hE9, 8'h30, 8'h04, 8'h04, 8'h01));
    endtask

    task automatic test_rejects();
        send_snapshot(snap_of(8'h00, 8'h0A, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h60, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h5F, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h24, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h02, 8'h00, 8'h00, 8'h20, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h02, 8'h00, 8'h00, 8'h13, 8'h01, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h32, 8'h00, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h07, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h01, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h13, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hA0));
        // leap day: only when the year divides by four
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h02, 8'h23));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h02, 8'h00));
        send_snapshot(snap_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h00, 8'h04, 8'h10));
        send_snapshot(snap_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_random_dates(input int count);
        t_snapshot snap;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            snap = random_date();
            // corrupt one register now and then
            if ($urandom_range(0, 7) == 0)
                snap[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
            send_snapshot(snap);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++)
            send_snapshot(t_snapshot'({$urandom, $urandom}));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_legal_extremes();
        test_rejects();
        test_random_dates(480);
        test_random_noise(120);
        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rsbd_pkg.sv
hw/rtl/rsbd_bcd.sv
hw/rtl/rsbd_decode.sv
hw/rtl/rtc_snapshot_bcd_decode.sv
hw/rtl/rsbd_checker.sv
verif/tb.sv
